FILE: sv/lgs_pkg.sv
`default_nettype none

package lgs_pkg;

  localparam int MAX_COLS = 512;
  localparam int MAX_ROWS = 512;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = 10;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int COLUMN_W = 6;
  localparam int WIN_W = 3 * COLUMN_W;
  localparam int CENTER_LSB = 2 * (3 * 1 + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int ODEPTH = 8;
  localparam int OPTR_W = $clog2(ODEPTH);

  localparam logic [1:0] ST_DEAD     = 2'd0;
  localparam logic [1:0] ST_SURVIVED = 2'd1;
  localparam logic [1:0] ST_BORN     = 2'd2;

  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    logic             restart;
  } lgs_cfg_t;

  // One request on its way from the front to the back. For a flush request,
  // col is the flush column and c_last marks the final column.
  typedef struct packed {
    logic                is_flush;
    logic [COL_W-1:0]    col;
    logic                c_ge1;
    logic                c_ge2;
    logic                c_last;
    logic                r_ge1;
    logic                r_ge2;
    logic                r_last;
    logic                rows_ge2;
    logic [1:0]          cell_val;
    logic [COLUMN_W-1:0] column;
  } lgs_item_t;

  typedef struct packed {
    logic [1:0] new_state;
    logic       changed;
    logic       last;
  } lgs_res_t;

  // B3/S23 on a 3x3 window; the column m, row k cell sits at bit 2*(3*m+k).
  function automatic logic [1:0] lgs_eval(input logic [WIN_W-1:0] w,
                                          input logic topv, input logic leftv,
                                          input logic rightv, input logic botv);
    logic [3:0] n;
    logic       rv;
    logic       cv;
    logic       alive;
    logic [1:0] ns;
    int         k;
    int         m;
    n = 4'd0;
    for (k = 0; k < 3; k++) begin
      for (m = 0; m < 3; m++) begin
        rv = (k == 0) ? topv : ((k == 2) ? botv : 1'b1);
        cv = (m == 0) ? leftv : ((m == 2) ? rightv : 1'b1);
        if (rv && cv && !(k == 1 && m == 1) && (w[2*(3*m+k) +: 2] != 2'b00)) begin
          n = n + 4'd1;
        end
      end
    end
    alive = (w[CENTER_LSB +: 2] != 2'b00);
    if (n == 4'd3) begin
      ns = alive ? ST_SURVIVED : ST_BORN;
    end else if (n == 4'd2) begin
      ns = alive ? ST_SURVIVED : ST_DEAD;
    end else begin
      ns = ST_DEAD;
    end
    return ns;
  endfunction

  // Moves the middle and bottom rows up one place and leaves the bottom empty.
  function automatic logic [WIN_W-1:0] lgs_drop_top(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    int               m;
    for (m = 0; m < 3; m++) begin
      r[COLUMN_W*m +: COLUMN_W] = {2'b00, w[COLUMN_W*m+2 +: 4]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/life_generation_stencil.sv
// Streaming Game of Life (B3/S23) next-generation engine. Old-generation cells
// come in one per request in raster order (a cell is alive when its state is
// nonzero) and new states come out in raster order: 2 for a birth, 1 for a
// survivor, 0 otherwise, with a flag set when the new state differs from the
// old raw state. Cells off the grid count as dead, with no wrap. A result for
// a cell is available once its lower-right neighbor has arrived, so the last
// row is drained by flush requests, one per column; the final flush result
// carries last_of_frame and starts a new frame. Cell requests arriving while
// the block waits for flushes, and flush requests arriving before all rows
// are in, are dropped without a result. The block takes one request per
// clock cycle while full is low; each request is registered, then queued, and
// its results are registered. The front stage reads and rewrites the two line
// buffers (one shared memory, one read and one write port per cycle), and a
// four-entry request queue lets it run ahead of the back stage, which holds
// the 3x3 window and works out up to two results per cycle into an
// eight-entry output queue. While the last row streams in, the back stage
// also works out that row's results into a column-deep memory, which the
// flush requests then read back one per cycle. The row_count and col_count
// registers sit at byte addresses 0 and 4; writing either one restarts the
// frame, and they should only be written while the block is idle.
`default_nettype none

module life_generation_stencil (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lgs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lgs_pkg::DATA_W-1:0] pwdata,
  output logic      [lgs_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       op,
  input  wire logic [1:0]                 cell_state,
  input  wire logic                       pop,
  output logic                            empty,
  output logic      [1:0]                 new_state,
  output logic                            changed,
  output logic                            last_of_frame
);

  lgs_pkg::lgs_cfg_t  cfg;
  logic               q_valid;
  lgs_pkg::lgs_item_t q_item;
  logic               q_pop;

  // Register file: effective row and column counts plus a restart strobe.
  lgs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front: position tracking, request classification and the line buffers.
  lgs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .op         (op),
    .cell_state (cell_state),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // Back: window, rule evaluation, last-row results and the output queue.
  lgs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .new_state     (new_state),
    .changed       (changed),
    .last_of_frame (last_of_frame)
  );

  // The back stage only takes a request that the front has queued.
  a_pop_needs_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("request queue popped while empty");

  // Window position flags handed to the back stage must be consistent.
  a_pos_flags: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_item.is_flush) |->
      ((!q_item.c_ge2 || q_item.c_ge1) && (!q_item.r_ge2 || q_item.r_ge1)))
    else $error("inconsistent position flags on a cell request");

  // Nothing is waiting at the output right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty)
    else $error("output queue not empty after reset");

  // A result offered at the output never carries undefined bits.
  a_result_known: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown({new_state, changed, last_of_frame}))
    else $error("undefined result offered at the output");

endmodule

`default_nettype wire

FILE: sv/lgs_cfg.sv
`default_nettype none

module lgs_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lgs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lgs_pkg::DATA_W-1:0] pwdata,
  output logic      [lgs_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output lgs_pkg::lgs_cfg_t               cfg
);

  logic [lgs_pkg::CNT_W-1:0] row_count;
  logic [lgs_pkg::CNT_W-1:0] col_count;
  logic                      wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= lgs_pkg::CNT_W'(lgs_pkg::MAX_ROWS);
      col_count <= lgs_pkg::CNT_W'(lgs_pkg::MAX_COLS);
    end else if (wr) begin
      unique case (paddr[lgs_pkg::ADDR_W-1])
        lgs_pkg::REG_ROW_COUNT: row_count <= pwdata[lgs_pkg::CNT_W-1:0];
        lgs_pkg::REG_COL_COUNT: col_count <= pwdata[lgs_pkg::CNT_W-1:0];
        default: row_count <= row_count;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[lgs_pkg::ADDR_W-1])
      lgs_pkg::REG_ROW_COUNT: prdata = lgs_pkg::DATA_W'(row_count);
      lgs_pkg::REG_COL_COUNT: prdata = lgs_pkg::DATA_W'(col_count);
      default: prdata = '0;
    endcase
  end

  // Zero counts as one, and values past the maximum saturate.
  always_comb begin
    if (row_count == '0) begin
      cfg.rows = lgs_pkg::CNT_W'(1);
    end else if (row_count > lgs_pkg::CNT_W'(lgs_pkg::MAX_ROWS)) begin
      cfg.rows = lgs_pkg::CNT_W'(lgs_pkg::MAX_ROWS);
    end else begin
      cfg.rows = row_count;
    end
    if (col_count == '0) begin
      cfg.cols = lgs_pkg::CNT_W'(1);
    end else if (col_count > lgs_pkg::CNT_W'(lgs_pkg::MAX_COLS)) begin
      cfg.cols = lgs_pkg::CNT_W'(lgs_pkg::MAX_COLS);
    end else begin
      cfg.cols = col_count;
    end
    cfg.restart = wr;
  end

endmodule

`default_nettype wire

FILE: sv/lgs_front.sv
`default_nettype none

module lgs_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lgs_pkg::lgs_cfg_t  cfg,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               op,
  input  wire logic [1:0]         cell_state,
  output logic                    q_valid,
  output lgs_pkg::lgs_item_t      q_item,
  input  wire logic               q_pop
);

  logic [lgs_pkg::CNT_W-1:0] row_pos;
  logic [lgs_pkg::COL_W-1:0] col_pos;
  logic [lgs_pkg::COL_W-1:0] flush_pos;

  logic                      accept;
  logic                      cell_take;
  logic                      flush_take;
  logic [lgs_pkg::CNT_W-1:0] cols_m1;
  logic                      c_last;
  logic                      f_last;
  lgs_pkg::lgs_item_t        s0_item;

  logic                      s1_valid;
  lgs_pkg::lgs_item_t        s1;
  logic                      s1_byp;
  logic [3:0]                s1_byp_data;

  // Line buffer entry: {middle row, upper row}.
  logic [3:0]                lmem [lgs_pkg::MAX_COLS];
  logic [3:0]                lmem_q;
  logic [3:0]                lrd;
  logic [3:0]                lwr_data;
  logic                      lwr_en;
  lgs_pkg::lgs_item_t        q_in;

  lgs_pkg::lgs_item_t        qmem [lgs_pkg::QDEPTH];
  logic [lgs_pkg::QPTR_W-1:0] q_wp;
  logic [lgs_pkg::QPTR_W-1:0] q_rp;
  logic [lgs_pkg::QPTR_W:0]   q_count;

  assign full = ((lgs_pkg::QPTR_W+2)'(q_count) + (lgs_pkg::QPTR_W+2)'(s1_valid))
                >= (lgs_pkg::QPTR_W+2)'(lgs_pkg::QDEPTH);
  assign accept = push & ~full;
  assign cols_m1 = cfg.cols - lgs_pkg::CNT_W'(1);
  assign c_last = (lgs_pkg::CNT_W'(col_pos) == cols_m1);
  assign f_last = (lgs_pkg::CNT_W'(flush_pos) == cols_m1);
  assign cell_take = accept & (op == lgs_pkg::OP_CELL) & (row_pos < cfg.rows);
  assign flush_take = accept & (op == lgs_pkg::OP_FLUSH) & (row_pos >= cfg.rows);

  always_comb begin
    s0_item.is_flush = (op == lgs_pkg::OP_FLUSH);
    s0_item.col      = s0_item.is_flush ? flush_pos : col_pos;
    s0_item.c_ge1    = (col_pos != '0);
    s0_item.c_ge2    = (col_pos >= lgs_pkg::COL_W'(2));
    s0_item.c_last   = s0_item.is_flush ? f_last : c_last;
    s0_item.r_ge1    = (row_pos != '0);
    s0_item.r_ge2    = (row_pos >= lgs_pkg::CNT_W'(2));
    s0_item.r_last   = (row_pos == cfg.rows - lgs_pkg::CNT_W'(1));
    s0_item.rows_ge2 = (cfg.rows >= lgs_pkg::CNT_W'(2));
    s0_item.cell_val = cell_state;
    s0_item.column   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      row_pos   <= '0;
      col_pos   <= '0;
      flush_pos <= '0;
    end else if (cell_take) begin
      if (c_last) begin
        col_pos <= '0;
        row_pos <= row_pos + lgs_pkg::CNT_W'(1);
      end else begin
        col_pos <= col_pos + lgs_pkg::COL_W'(1);
      end
    end else if (flush_take) begin
      if (f_last) begin
        row_pos   <= '0;
        col_pos   <= '0;
        flush_pos <= '0;
      end else begin
        flush_pos <= flush_pos + lgs_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cell_take | flush_take;
    end
  end

  // A cell request reading the column that the request ahead of it is
  // writing back in the same cycle takes the fresh data instead.
  always_ff @(posedge clk) begin
    s1          <= s0_item;
    s1_byp      <= s1_valid & ~s1.is_flush & (s1.col == col_pos);
    s1_byp_data <= lwr_data;
  end

  assign lrd = s1_byp ? s1_byp_data : lmem_q;
  assign lwr_data = {s1.cell_val, lrd[3:2]};
  assign lwr_en = s1_valid & ~s1.is_flush;

  always_ff @(posedge clk) begin
    if (cell_take) begin
      lmem_q <= lmem[col_pos];
    end
    if (lwr_en) begin
      lmem[s1.col] <= lwr_data;
    end
  end

  always_comb begin
    q_in        = s1;
    q_in.column = {s1.cell_val, lrd[3:2], lrd[1:0]};
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      qmem[q_wp] <= q_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp    <= '0;
      q_rp    <= '0;
      q_count <= '0;
    end else begin
      if (s1_valid) begin
        q_wp <= q_wp + lgs_pkg::QPTR_W'(1);
      end
      if (q_pop) begin
        q_rp <= q_rp + lgs_pkg::QPTR_W'(1);
      end
      q_count <= q_count + (lgs_pkg::QPTR_W+1)'(s1_valid) - (lgs_pkg::QPTR_W+1)'(q_pop);
    end
  end

  assign q_valid = (q_count != '0);
  assign q_item = qmem[q_rp];

endmodule

`default_nettype wire

FILE: sv/lgs_back.sv
`default_nettype none

module lgs_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  wire lgs_pkg::lgs_item_t q_item,
  output logic                    q_pop,
  input  wire logic               pop,
  output logic                    empty,
  output logic [1:0]              new_state,
  output logic                    changed,
  output logic                    last_of_frame
);

  logic [lgs_pkg::WIN_W-1:0] win;
  logic [lgs_pkg::WIN_W-1:0] ws;
  logic [lgs_pkg::WIN_W-1:0] w2;
  logic [lgs_pkg::WIN_W-1:0] fws;
  logic [lgs_pkg::WIN_W-1:0] fw2;
  logic [2:0]                r0;
  logic [2:0]                r1;
  logic [2:0]                fr0;
  logic [2:0]                fr1;
  logic                      a_go;
  logic                      cell_go;
  logic                      flush_go;

  // Last-row results worked out ahead of the flush requests: {state, changed}.
  logic [2:0]                fmem [lgs_pkg::MAX_COLS];
  logic [2:0]                fmem_q;
  logic [2:0]                tail;

  logic                      b_fv;
  logic                      b_last;
  logic                      b_r0v;
  logic                      b_r1v;
  logic [2:0]                b_r0;
  logic [2:0]                b_r1;
  logic [2:0]                fsel;

  lgs_pkg::lgs_res_t         ofifo [lgs_pkg::ODEPTH];
  logic [lgs_pkg::OPTR_W-1:0] o_wp;
  logic [lgs_pkg::OPTR_W-1:0] o_rp;
  logic [lgs_pkg::OPTR_W:0]   ocount;
  logic                       o_pop;
  logic [1:0]                 n_push;
  lgs_pkg::lgs_res_t          e0;
  lgs_pkg::lgs_res_t          e1;

  function automatic logic [2:0] pack_res(input logic [1:0] ns, input logic [1:0] raw);
    return {ns, ns != raw};
  endfunction

  assign a_go = q_valid & (ocount <= (lgs_pkg::OPTR_W+1)'(lgs_pkg::ODEPTH - 4));
  assign q_pop = a_go;
  assign cell_go = a_go & ~q_item.is_flush;
  assign flush_go = a_go & q_item.is_flush;

  always_comb begin
    ws  = {q_item.column, win[lgs_pkg::WIN_W-1:lgs_pkg::COLUMN_W]};
    w2  = {lgs_pkg::COLUMN_W'(0), ws[lgs_pkg::WIN_W-1:lgs_pkg::COLUMN_W]};
    fws = lgs_pkg::lgs_drop_top(ws);
    fw2 = lgs_pkg::lgs_drop_top(w2);
    r0  = pack_res(lgs_pkg::lgs_eval(ws, q_item.r_ge2, q_item.c_ge2, 1'b1, 1'b1),
                   ws[lgs_pkg::CENTER_LSB +: 2]);
    r1  = pack_res(lgs_pkg::lgs_eval(w2, q_item.r_ge2, q_item.c_ge1, 1'b0, 1'b1),
                   w2[lgs_pkg::CENTER_LSB +: 2]);
    fr0 = pack_res(lgs_pkg::lgs_eval(fws, q_item.rows_ge2, q_item.c_ge2, 1'b1, 1'b0),
                   fws[lgs_pkg::CENTER_LSB +: 2]);
    fr1 = pack_res(lgs_pkg::lgs_eval(fw2, q_item.rows_ge2, q_item.c_ge1, 1'b0, 1'b0),
                   fw2[lgs_pkg::CENTER_LSB +: 2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_fv  <= 1'b0;
      b_r0v <= 1'b0;
      b_r1v <= 1'b0;
    end else begin
      b_fv  <= flush_go;
      b_r0v <= cell_go & q_item.r_ge1 & q_item.c_ge1;
      b_r1v <= cell_go & q_item.r_ge1 & q_item.c_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_go) begin
      win  <= (q_item.r_ge1 & q_item.c_last) ? w2 : ws;
      b_r0 <= r0;
      b_r1 <= r1;
      if (q_item.r_last & q_item.c_ge1) begin
        fmem[q_item.col - lgs_pkg::COL_W'(1)] <= fr0;
      end
      if (q_item.r_last & q_item.c_last) begin
        tail <= fr1;
      end
    end
    if (flush_go) begin
      fmem_q <= fmem[q_item.col];
      b_last <= q_item.c_last;
    end
  end

  assign fsel = b_last ? tail : fmem_q;

  always_comb begin
    if (b_fv) begin
      e0     = {fsel, b_last};
      e1     = {fsel, b_last};
      n_push = 2'd1;
    end else begin
      e0     = b_r0v ? {b_r0, 1'b0} : {b_r1, 1'b0};
      e1     = {b_r1, 1'b0};
      n_push = 2'(b_r0v) + 2'(b_r1v);
    end
  end

  assign o_pop = pop & ~empty;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      ofifo[o_wp] <= e0;
    end
    if (n_push == 2'd2) begin
      ofifo[o_wp + lgs_pkg::OPTR_W'(1)] <= e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wp   <= '0;
      o_rp   <= '0;
      ocount <= '0;
    end else begin
      o_wp <= o_wp + lgs_pkg::OPTR_W'(n_push);
      if (o_pop) begin
        o_rp <= o_rp + lgs_pkg::OPTR_W'(1);
      end
      ocount <= ocount + (lgs_pkg::OPTR_W+1)'(n_push) - (lgs_pkg::OPTR_W+1)'(o_pop);
    end
  end

  assign empty = (ocount == '0);
  assign new_state = ofifo[o_rp].new_state;
  assign changed = ofifo[o_rp].changed;
  assign last_of_frame = ofifo[o_rp].last;

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

// Streams old-generation cells and flush requests into the Game of Life
// stencil, keeps its own line buffers and 3x3 window, and checks every new
// state, change flag and end-of-frame mark in the order they leave the block.
module testbench;

  localparam int GAP_LIMIT      = 14;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_ITEMS   = 350;
  localparam int PRINT_LIMIT    = 50;

  // One request for the input side, with the idle cycles that precede it.
  typedef struct {
    logic        op_code;
    logic [1:0]  cell_val;
    int unsigned gap;
  } request_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [lgs_pkg::ADDR_W-1:0]   paddr = '0;
  logic [lgs_pkg::DATA_W-1:0]   pwdata = '0;
  logic [lgs_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         push = 1'b0;
  logic                         full;
  logic                         op = lgs_pkg::OP_CELL;
  logic [1:0]                   cell_state = 2'd0;
  logic                         pop = 1'b0;
  logic                         empty;
  logic [1:0]                   new_state;
  logic                         changed;
  logic                         last_of_frame;

  always #1 clk = ~clk;

  life_generation_stencil DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .push(push),
    .full(full),
    .op(op),
    .cell_state(cell_state),
    .pop(pop),
    .empty(empty),
    .new_state(new_state),
    .changed(changed),
    .last_of_frame(last_of_frame)
  );

  // ---------------------------------------------------------------------------
  // Predicted behavior of the stencil. The two line buffers hold the previous
  // two rows per column; the window holds three columns of three cells, column
  // m and row k (0 = top) at bit 2*(3*m+k), newest column at the top bits.
  // ---------------------------------------------------------------------------
  logic [1:0]        upper_row [lgs_pkg::MAX_COLS];
  logic [1:0]        middle_row [lgs_pkg::MAX_COLS];
  logic [17:0]       win;
  int unsigned       row_at;
  int unsigned       col_at;
  int unsigned       flush_at;
  logic [9:0]        rows_setting;
  logic [9:0]        cols_setting;
  lgs_pkg::lgs_res_t predicted_cells [$];

  // A zero register acts as one and anything past the build limit saturates.
  function automatic int unsigned clamp_count(input logic [9:0] v, input int unsigned top);
    if (v == 10'd0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  // B3/S23: counts live neighbors inside the valid rows and columns only.
  function automatic logic [1:0] life_rule(input logic [17:0] w, input logic top_ok,
                                           input logic left_ok, input logic right_ok,
                                           input logic bottom_ok);
    logic [2:0]  row_ok;
    logic [2:0]  col_ok;
    logic        center_alive;
    int unsigned neighbors;
    int          k;
    int          m;
    row_ok = {bottom_ok, 1'b1, top_ok};
    col_ok = {right_ok, 1'b1, left_ok};
    neighbors = 0;
    for (m = 0; m < 3; m++) begin
      for (k = 0; k < 3; k++) begin
        if (row_ok[k] && col_ok[m] && !(k == 1 && m == 1) && w[6*m+2*k +: 2] != 2'd0) begin
          neighbors++;
        end
      end
    end
    center_alive = (w[8 +: 2] != 2'd0);
    if (neighbors == 3) return center_alive ? lgs_pkg::ST_SURVIVED : lgs_pkg::ST_BORN;
    if (neighbors == 2 && center_alive) return lgs_pkg::ST_SURVIVED;
    return lgs_pkg::ST_DEAD;
  endfunction

  function automatic void expect_cell(input logic [1:0] next, input logic [1:0] old_raw,
                                      input logic last);
    lgs_pkg::lgs_res_t r;
    r.new_state = next;
    r.changed = (next != old_raw);
    r.last = last;
    predicted_cells.push_back(r);
  endfunction

  // The line buffers are left alone; rows that are off the grid are masked.
  function automatic void restart_frame();
    win = '0;
    row_at = 0;
    col_at = 0;
    flush_at = 0;
  endfunction

  // Works out the results of one accepted request.
  function automatic void step_generation(input logic op_code, input logic [1:0] cell_val);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    int unsigned f;
    logic [5:0]  column;
    logic [17:0] w;
    rows = clamp_count(rows_setting, lgs_pkg::MAX_ROWS);
    cols = clamp_count(cols_setting, lgs_pkg::MAX_COLS);
    if (op_code == lgs_pkg::OP_CELL) begin
      r = row_at;
      c = col_at;
      // Once every row is in, cells are dropped until the flush is done.
      if (r >= rows || c >= cols) return;
      column = {cell_val, middle_row[c], upper_row[c]};
      win = {column, win[17:6]};
      upper_row[c] = middle_row[c];
      middle_row[c] = cell_val;
      if (r >= 1) begin
        if (c >= 1) begin
          expect_cell(life_rule(win, r >= 2, c >= 2, 1'b1, 1'b1), win[8 +: 2], 1'b0);
        end
        // The end of a row also settles the cell above it, whose right side is
        // off the grid.
        if (c == cols - 1) begin
          win = {6'd0, win[17:6]};
          expect_cell(life_rule(win, r >= 2, c >= 1, 1'b0, 1'b1), win[8 +: 2], 1'b0);
        end
      end
      col_at = c + 1;
      if (col_at >= cols) begin
        col_at = 0;
        row_at = r + 1;
      end
    end else begin
      // A flush before the last row is complete does nothing.
      if (row_at < rows) return;
      f = flush_at;
      if (f >= cols) begin
        restart_frame();
        return;
      end
      w = '0;
      if (f >= 1) w[5:0] = {middle_row[f-1], upper_row[f-1]};
      w[11:6] = {middle_row[f], upper_row[f]};
      if (f + 1 < cols) w[17:12] = {middle_row[f+1], upper_row[f+1]};
      expect_cell(life_rule(w, rows >= 2, f >= 1, f + 1 < cols, 1'b0), w[8 +: 2],
                  f + 1 >= cols);
      flush_at = f + 1;
      if (f + 1 >= cols) restart_frame();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch bookkeeping. Only the first lines are printed so a broken block
  // cannot flood the log, but every mismatch is counted.
  // ---------------------------------------------------------------------------
  int unsigned mismatches = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver. The stimulus process fills the request queue; this block offers
  // the oldest entry once its idle gap has elapsed, and hands each accepted
  // request to the predictor at the edge that takes it.
  // ---------------------------------------------------------------------------
  request_t    queued_requests [$];
  request_t    next_request;
  int unsigned tx_idle = 0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      tx_idle = 0;
    end else begin
      if (push && !full) step_generation(op, cell_state);
      // A request that is still refused stays on the bus unchanged.
      if (!push || !full) begin
        if (queued_requests.size() != 0 && tx_idle >= queued_requests[0].gap) begin
          next_request = queued_requests.pop_front();
          op <= next_request.op_code;
          cell_state <= next_request.cell_val;
          push <= 1'b1;
          tx_idle = 0;
        end else begin
          push <= 1'b0;
          if (queued_requests.size() != 0) tx_idle++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Takes results with a random stall before each one, now and then
  // switching to a run with no stalls. When the stimulus asks for it, it also
  // holds pop low for a long stretch so the output queue backs up into the
  // request queue and full is raised.
  // ---------------------------------------------------------------------------
  lgs_pkg::lgs_res_t want;
  logic              taken;
  logic              rx_steady = 1'b0;
  int unsigned       rx_wait = 0;
  int unsigned       results_taken = 0;
  int unsigned       hold_left = 0;
  int unsigned       hold_off_requests = 0;
  int unsigned       hold_off_served = 0;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      taken = pop && !empty;
      if (taken) begin
        if (predicted_cells.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none due: %0d %0d %0d",
                                    results_taken, new_state, changed, last_of_frame));
        end else begin
          want = predicted_cells.pop_front();
          if (new_state !== want.new_state || changed !== want.changed ||
              last_of_frame !== want.last) begin
            report_mismatch($sformatf(
              "result %0d: new_state/changed/last got %0d %0d %0d, want %0d %0d %0d",
              results_taken, new_state, changed, last_of_frame,
              want.new_state, want.changed, want.last));
          end
        end
        results_taken++;
        if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
        rx_wait = rx_steady ? 0 : $urandom_range(0, GAP_LIMIT);
      end
      if (hold_off_served != hold_off_requests) begin
        hold_off_served = hold_off_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (taken || !pop) begin
        if (rx_wait > 0) begin
          rx_wait--;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a run of cycles in which neither side moves a request or a
  // result ends the run as a failure. The limit covers the long hold-off.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) stuck = 0;
      else stuck++;
    end
    $display("life_generation_stencil: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  int unsigned gap_max = GAP_LIMIT;
  int unsigned frame_items = 0;

  task automatic queue_request(input logic op_code, input logic [1:0] cell_val);
    request_t q;
    q.op_code = op_code;
    q.cell_val = cell_val;
    q.gap = $urandom_range(0, gap_max);
    queued_requests.push_back(q);
  endtask

  // Every request taken, every result popped, and time for anything still in
  // the pipeline that yields no result to clear before the registers change.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (queued_requests.size() != 0 || push || predicted_cells.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the value at
  // the edge that ends the access cycle. Any write restarts the frame.
  task automatic write_register(input logic index, input logic [9:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= {22'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == lgs_pkg::REG_ROW_COUNT) rows_setting = value;
    else cols_setting = value;
    restart_frame();
  endtask

  // Queues one frame in raster order followed by its flush requests, cut off
  // after stop_after requests. A few stray requests are mixed in: flushes
  // while rows are still coming and cells while the flush runs, which the
  // block must drop.
  task automatic queue_frame(input int unsigned rows, input int unsigned cols,
                             input int unsigned stop_after);
    int unsigned density;
    int unsigned n;
    density = $urandom_range(0, 4);
    for (n = 0; n < rows * cols + cols && n < stop_after; n++) begin
      if (n < rows * cols) begin
        if ($urandom_range(0, 29) == 0) begin
          queue_request(lgs_pkg::OP_FLUSH, 2'($urandom_range(0, 3)));
        end
        queue_request(lgs_pkg::OP_CELL,
                      ($urandom_range(1, 4) <= density) ? 2'($urandom_range(1, 3)) : 2'd0);
      end else begin
        if ($urandom_range(0, 29) == 0) begin
          queue_request(lgs_pkg::OP_CELL, 2'($urandom_range(0, 3)));
        end
        queue_request(lgs_pkg::OP_FLUSH, 2'($urandom_range(0, 3)));
      end
      frame_items++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned i;
    int unsigned rsel;
    int unsigned csel;
    int unsigned pattern;
    int unsigned rows_eff;
    int unsigned cols_eff;
    int unsigned stop_after;
    logic [9:0]  rows_val;
    logic [9:0]  cols_val;
    logic        aborted;

    for (i = 0; i < lgs_pkg::MAX_COLS; i++) begin
      upper_row[i] = 2'd0;
      middle_row[i] = 2'd0;
    end
    rows_setting = 10'd512;
    cols_setting = 10'd512;
    restart_frame();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A zero row count means one row. The single row comes out through the
    // flush alone; the raw state 3 counts as alive and always changes. A flush
    // before the row is complete and a cell once it is complete are dropped.
    write_register(lgs_pkg::REG_ROW_COUNT, 10'd0);
    write_register(lgs_pkg::REG_COL_COUNT, 10'd3);
    queue_request(lgs_pkg::OP_CELL, 2'd3);
    queue_request(lgs_pkg::OP_FLUSH, 2'd0);
    queue_request(lgs_pkg::OP_CELL, 2'd0);
    queue_request(lgs_pkg::OP_CELL, 2'd2);
    queue_request(lgs_pkg::OP_CELL, 2'd1);
    queue_request(lgs_pkg::OP_FLUSH, 2'd3);
    queue_request(lgs_pkg::OP_FLUSH, 2'd0);
    queue_request(lgs_pkg::OP_FLUSH, 2'd1);
    wait_until_idle();

    // A vertical blinker in a 3x3 grid: two births, one survivor, edge cells
    // on every side.
    write_register(lgs_pkg::REG_ROW_COUNT, 10'd3);
    write_register(lgs_pkg::REG_COL_COUNT, 10'd3);
    for (i = 0; i < 9; i++) queue_request(lgs_pkg::OP_CELL, (i % 3 == 1) ? 2'd1 : 2'd0);
    for (i = 0; i < 3; i++) queue_request(lgs_pkg::OP_FLUSH, 2'd2);
    wait_until_idle();

    // An oversized row count saturates; one column means every cell both opens
    // and closes its row. The frame is cut short by the next register write.
    write_register(lgs_pkg::REG_ROW_COUNT, 10'd1023);
    write_register(lgs_pkg::REG_COL_COUNT, 10'd1);
    queue_request(lgs_pkg::OP_CELL, 2'd1);
    queue_request(lgs_pkg::OP_CELL, 2'd2);
    queue_request(lgs_pkg::OP_CELL, 2'd3);
    queue_request(lgs_pkg::OP_CELL, 2'd0);
    queue_request(lgs_pkg::OP_FLUSH, 2'd1);
    wait_until_idle();

    // Back-pressure: a dense frame sent with no gaps while the monitor stops
    // popping, so both internal queues fill and full must hold the sender.
    write_register(lgs_pkg::REG_ROW_COUNT, 10'd8);
    write_register(lgs_pkg::REG_COL_COUNT, 10'd10);
    gap_max = 0;
    queue_frame(8, 10, 1000);
    hold_off_requests++;
    wait_until_idle();

    // The widest grid: one row of the saturated column count, drained by 512
    // flush requests.
    gap_max = GAP_LIMIT;
    write_register(lgs_pkg::REG_ROW_COUNT, 10'd0);
    write_register(lgs_pkg::REG_COL_COUNT, 10'd1023);
    queue_frame(1, lgs_pkg::MAX_COLS, 2 * lgs_pkg::MAX_COLS);
    wait_until_idle();

    // Random frames, mostly small and complete, some cut short, some run back
    // to back without a register write in between.
    frame_items = 0;
    aborted = 1'b1;
    while (frame_items < RANDOM_ITEMS) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_LIMIT;
      if (aborted || $urandom_range(0, 3) != 0) begin
        wait_until_idle();
        rsel = $urandom_range(0, 19);
        csel = $urandom_range(0, 19);
        if (rsel == 0) rows_val = 10'd0;
        else if (rsel == 1) rows_val = 10'd512;
        else if (rsel == 2) rows_val = 10'd1023;
        else rows_val = 10'($urandom_range(1, 8));
        if (csel == 0) cols_val = 10'd0;
        else if (csel == 1) cols_val = 10'($urandom_range(17, 40));
        else cols_val = 10'($urandom_range(1, 16));
        pattern = aborted ? 0 : $urandom_range(0, 2);
        if (pattern != 2) write_register(lgs_pkg::REG_ROW_COUNT, rows_val);
        if (pattern != 1) write_register(lgs_pkg::REG_COL_COUNT, cols_val);
      end
      rows_eff = clamp_count(rows_setting, lgs_pkg::MAX_ROWS);
      cols_eff = clamp_count(cols_setting, lgs_pkg::MAX_COLS);
      if (rows_eff > 16 || cols_eff > 40) begin
        // Too large to finish: send the first rows and abandon the frame.
        stop_after = $urandom_range(1, 3 * cols_eff);
        aborted = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        stop_after = $urandom_range(1, rows_eff * cols_eff + cols_eff);
        aborted = 1'b1;
      end else begin
        stop_after = rows_eff * cols_eff + cols_eff;
        aborted = 1'b0;
      end
      if (stop_after >= rows_eff * cols_eff + cols_eff) aborted = 1'b0;
      queue_frame(rows_eff, cols_eff, stop_after);
    end

    wait_until_idle();
    if (mismatches == 0) begin
      $display("life_generation_stencil: match");
    end else begin
      $display("life_generation_stencil: mismatch");
    end
    $finish;
  end

endmodule
